[src/ptbs_pkg.sv]
// Package for the positional table: sizes, codes, field widths and preset entries.
package ptbs_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int PRESET_COUNT = 5;
  localparam int AW           = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = 8;
  localparam int IN_W         = 80;
  localparam int OUT_W        = 80;
  localparam int ENTRY_W      = 64;

  localparam logic [CNT_W-1:0] START_COUNT =
    CNT_W'((PRESET_COUNT < TABLE_DEPTH) ? PRESET_COUNT : TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_EDIT   = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_SORT   = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  // Entry word: id in the upper half, price in the lower half.
  function automatic logic [ENTRY_W-1:0] preset_entry(input logic [2:0] idx);
    logic [ENTRY_W-1:0] e;
    case (idx)
      3'd0:    e = {32'd1, 32'd45000};
      3'd1:    e = {32'd2, 32'd40000};
      3'd2:    e = {32'd3, 32'd20000};
      3'd3:    e = {32'd4, 32'd50000};
      3'd4:    e = {32'd5, 32'd15000};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[src/positional_table_with_bubble_sort_top.sv]
// Positional (id, price) table with insert, edit, delete, bubble sort and read.
// How long a transaction runs is set by the single memory read port and the one price
// comparator; the result goes out as ready returns.
// One transaction in flight; the result register lets the next one start while it waits.
// Reset (async, active low) runs a preload of the preset entries, one per cycle,
// before the input is ready; count starts at the preset count.
module positional_table_with_bubble_sort_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] position, [39:8] new_id, [71:40] new_price, [72] sort_order, zero fill
  input  logic [ptbs_pkg::IN_W-1:0]  s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] status, [33:2] entry_id, [65:34] entry_price, [73:66] entry_count, zero fill
  output logic [ptbs_pkg::OUT_W-1:0] m_axis_tdata
);
  import ptbs_pkg::*;

  typedef enum logic [11:0] {
    S_INIT   = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_INS_RD = 12'b000000000100,
    S_INS_WR = 12'b000000001000,
    S_DEL_RD = 12'b000000010000,
    S_DEL_WR = 12'b000000100000,
    S_RD_WT  = 12'b000001000000,
    S_SLOAD  = 12'b000010000000,
    S_SRD    = 12'b000100000000,
    S_SCMP   = 12'b001000000000,
    S_SEND   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_d, state_q;

  logic [CNT_W-1:0]   count_d, count_q;
  logic [CNT_W-1:0]   idx_d, idx_q;
  logic [CNT_W-1:0]   pend_d, pend_q;
  logic [CNT_W-1:0]   pos_d, pos_q;
  logic [ENTRY_W-1:0] new_d, new_q;
  logic [ENTRY_W-1:0] cur_d, cur_q;
  logic               asc_d, asc_q;
  logic [1:0]         res_status_d, res_status_q;
  logic [ENTRY_W-1:0] res_entry_d, res_entry_q;
  logic               m_valid_d, m_valid_q;
  logic [OUT_W-1:0]   m_data_d, m_data_q;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata;

  logic [CNT_W-1:0]   in_pos;
  logic [ENTRY_W-1:0] in_entry;
  logic               in_asc;
  logic [CNT_W-1:0]   idx_inc, idx_dec, pos_dec, pos_q_dec;
  logic [CNT_W:0]     count_inc;
  logic               accept, do_swap;

  assign in_pos   = s_axis_tdata[7:0];
  assign in_entry = {s_axis_tdata[39:8], s_axis_tdata[71:40]};
  assign in_asc   = s_axis_tdata[72];
  assign idx_inc  = idx_q + CNT_W'(1);
  assign idx_dec  = idx_q - CNT_W'(1);
  assign pos_dec  = in_pos - CNT_W'(1);
  assign pos_q_dec = pos_q - CNT_W'(1);
  assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Single price comparator for the bubble pass: carried entry against the next one.
  assign do_swap = asc_q ? (cur_q[31:0] > rdata_q[31:0]) : (cur_q[31:0] < rdata_q[31:0]);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pos_d        = pos_q;
    new_d        = new_q;
    cur_d        = cur_q;
    asc_d        = asc_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    we           = 1'b0;
    waddr        = idx_q[AW-1:0];
    wdata        = rdata_q;
    raddr        = '0;

    case (state_q)
      S_INIT: begin
        if (idx_q < START_COUNT) begin
          we    = 1'b1;
          wdata = preset_entry(idx_q[2:0]);
          idx_d = idx_inc;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pos_d        = in_pos;
          new_d        = in_entry;
          asc_d        = in_asc;
          res_status_d = ST_DONE;
          res_entry_d  = '0;
          state_d      = S_DONE;
          case (kind_e'(s_axis_tuser))
            KIND_INSERT: begin
              if (count_q >= DEPTH_CNT) begin
                res_status_d = ST_FULL;
              end else if (in_pos == '0 || {1'b0, in_pos} > count_inc) begin
                res_status_d = ST_BAD_POS;
              end else begin
                idx_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            KIND_EDIT: begin
              if (in_pos == '0 || in_pos > count_q) begin
                res_status_d = ST_BAD_POS;
              end else begin
                we    = 1'b1;
                waddr = pos_dec[AW-1:0];
                wdata = in_entry;
              end
            end
            KIND_DELETE: begin
              if (in_pos == '0 || in_pos > count_q) begin
                res_status_d = ST_BAD_POS;
              end else begin
                idx_d   = pos_dec;
                state_d = S_DEL_RD;
              end
            end
            KIND_SORT: begin
              if (count_q >= CNT_W'(2)) begin
                pend_d  = count_q - CNT_W'(1);
                raddr   = '0;
                state_d = S_SLOAD;
              end
            end
            KIND_READ: begin
              if (in_pos == '0 || in_pos > count_q) begin
                res_status_d = ST_BAD_POS;
              end else begin
                raddr   = pos_dec[AW-1:0];
                state_d = S_RD_WT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Shift up from the top down to the insert point, then place the new entry.
      S_INS_RD: begin
        if (idx_q >= pos_q) begin
          raddr   = idx_dec[AW-1:0];
          state_d = S_INS_WR;
        end else begin
          we      = 1'b1;
          waddr   = pos_q_dec[AW-1:0];
          wdata   = new_q;
          count_d = count_inc[CNT_W-1:0];
          state_d = S_DONE;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        idx_d   = idx_dec;
        state_d = S_INS_RD;
      end
      // Shift down over the deleted slot.
      S_DEL_RD: begin
        if (idx_inc < count_q) begin
          raddr   = idx_inc[AW-1:0];
          state_d = S_DEL_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_DEL_WR: begin
        we      = 1'b1;
        idx_d   = idx_inc;
        state_d = S_DEL_RD;
      end
      S_RD_WT: begin
        res_entry_d = rdata_q;
        state_d     = S_DONE;
      end
      // Bubble pass: carry the entry that is moving and write back the one left behind.
      S_SLOAD: begin
        cur_d   = rdata_q;
        idx_d   = '0;
        state_d = S_SRD;
      end
      S_SRD: begin
        raddr   = idx_inc[AW-1:0];
        state_d = S_SCMP;
      end
      S_SCMP: begin
        we = 1'b1;
        if (do_swap) begin
          wdata = rdata_q;
        end else begin
          wdata = cur_q;
          cur_d = rdata_q;
        end
        idx_d   = idx_inc;
        state_d = (idx_inc == pend_q) ? S_SEND : S_SRD;
      end
      S_SEND: begin
        we     = 1'b1;
        waddr  = pend_q[AW-1:0];
        wdata  = cur_q;
        pend_d = pend_q - CNT_W'(1);
        raddr  = '0;
        state_d = (pend_q == CNT_W'(1)) ? S_DONE : S_SLOAD;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({count_q, res_entry_q[31:0], res_entry_q[63:32], res_status_q});
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= START_COUNT;
      idx_q     <= '0;
      pend_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    new_q        <= new_d;
    cur_q        <= cur_d;
    asc_q        <= asc_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    m_data_q     <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("ready again right after a transaction");

  a_fail_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[1:0] != ST_DONE) |-> (m_data_q[65:2] == '0))
    else $error("failed request returned entry data");

endmodule
